// ===== design/hanbr_pkg.sv =====
// ----------------------------------------------------------------------------
// hanbr_pkg
// Shared types, codes and the sequencer program of the best response unit.
// ----------------------------------------------------------------------------
package hanbr_pkg;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  localparam logic [1:0] SUPPORT_PAIR   = 2'd2;
  localparam logic [1:0] SUPPORT_TRIPLE = 2'd3;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 7;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 8'd1;

  typedef struct packed {
    logic        func;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [31:0] row_payoff;
    logic [31:0] col_payoff;
    logic [7:0]  start_strategy;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       player_side;
    logic [5:0] first_strategy;
    logic [5:0] response_strategy;
    logic [5:0] second_strategy;
    logic [1:0] support_size;
  } out_item_t;

  // datapath operation of one step
  typedef enum logic [2:0] {
    OP_NONE,
    OP_WAIT,
    OP_DECODE,
    OP_ISSUE_A,
    OP_ISSUE_B,
    OP_TAKE_RESP,
    OP_FINISH,
    OP_EMIT
  } op_e;

  // next step selection
  typedef enum logic [2:0] {
    C_NEXT,
    C_ACCEPT,
    C_EARLY,
    C_MORE,
    C_OUT_FREE,
    C_JUMP
  } cond_e;

  typedef logic [3:0] pc_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic fire;
    logic early;
    logic more;
    logic out_free;
  } seq_stat_t;

  localparam pc_t PC_WAIT    = 4'd0;
  localparam pc_t PC_DECODE  = 4'd1;
  localparam pc_t PC_A_ISSUE = 4'd2;
  localparam pc_t PC_A_DRAIN = 4'd3;
  localparam pc_t PC_TAKE    = 4'd4;
  localparam pc_t PC_B_ISSUE = 4'd5;
  localparam pc_t PC_B_DRAIN = 4'd6;
  localparam pc_t PC_FINISH  = 4'd7;
  localparam pc_t PC_EMIT    = 4'd8;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    case (pc)
      PC_WAIT:    w = '{op: OP_WAIT,      cond: C_ACCEPT,   target: PC_WAIT};
      PC_DECODE:  w = '{op: OP_DECODE,    cond: C_EARLY,    target: PC_EMIT};
      PC_A_ISSUE: w = '{op: OP_ISSUE_A,   cond: C_MORE,     target: PC_A_ISSUE};
      PC_A_DRAIN: w = '{op: OP_NONE,      cond: C_NEXT,     target: PC_WAIT};
      PC_TAKE:    w = '{op: OP_TAKE_RESP, cond: C_NEXT,     target: PC_WAIT};
      PC_B_ISSUE: w = '{op: OP_ISSUE_B,   cond: C_MORE,     target: PC_B_ISSUE};
      PC_B_DRAIN: w = '{op: OP_NONE,      cond: C_NEXT,     target: PC_WAIT};
      PC_FINISH:  w = '{op: OP_FINISH,    cond: C_NEXT,     target: PC_WAIT};
      PC_EMIT:    w = '{op: OP_EMIT,      cond: C_OUT_FREE, target: PC_WAIT};
      default:    w = '{op: OP_NONE,      cond: C_JUMP,     target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== design/half_approx_nash_best_response_unit.sv =====
// ----------------------------------------------------------------------------
// half_approx_nash_best_response_unit
// Half-approximate Nash profile from two chained best-response scans.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : a load item writes one payoff cell pair; a run item names a
//                 one-based start strategy over rows then columns.
//   out channel : one result item per input item (all zero for loads).
//   cfg channel : index 0 row_count, index 1 col_count; always ready, write
//                 only while idle.
//   Flow        : a load or a bad start goes from decode straight to emit; a
//                 run first does two argmax scans, rows + cols payoffs in all,
//                 which read one payoff per cycle from the single read port
//                 of the payoff memories.
//   Throughput  : one item at a time; the next item can be taken in the cycle
//                 after the result is parked in the output register.
//   Reset       : counts return to 1, sequencer idles; payoff memories are
//                 not cleared and must be loaded before a run reads them.
//   Stall       : a held result stays in the output register; a following
//                 item may still be processed and waits for that register.
// ----------------------------------------------------------------------------
module half_approx_nash_best_response_unit import hanbr_pkg::*; #(
  parameter int MAX_STRATEGIES = 64,
  parameter int PAYOFF_WIDTH   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(MAX_STRATEGIES);
  localparam int AW    = 2 * IDX_W;
  localparam int CNT_W = IDX_W + 1;
  localparam int SW    = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (32'(c) > MAX_STRATEGIES) begin
      r = CNT_W'(MAX_STRATEGIES);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

  function automatic logic [PAYOFF_WIDTH-1:0] to_payoff(input logic [31:0] x);
    logic [63:0] ext;
    ext = {{32{x[31]}}, x};
    return ext[PAYOFF_WIDTH-1:0];
  endfunction

  ctrl_t     ctrl;
  seq_stat_t stat;

  in_item_t         item_q;
  logic [COUNT_W-1:0] row_cnt_q, col_cnt_q;
  logic             side_q;
  logic [IDX_W-1:0] first_q, resp_q, t_q;
  out_item_t        res_q, out_q;
  logic             out_vld_q;

  logic             fire;
  logic [CNT_W-1:0] m, n, len;
  logic [SW-1:0]    start_w, sum_w, s_w, first_w;
  logic             bad, side_run, in_range;
  logic             issue, kind;
  logic [IDX_W-1:0] fixed, best;
  logic [AW-1:0]    rd_addr, wr_addr;

  hanbr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign in_ready_o  = (ctrl.op == OP_WAIT);
  assign fire        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // start strategy decode
  always_comb begin
    m        = clamp_count(row_cnt_q);
    n        = clamp_count(col_cnt_q);
    start_w  = SW'(item_q.start_strategy);
    sum_w    = SW'(m) + SW'(n);
    bad      = (start_w == '0) || (start_w > sum_w);
    s_w      = start_w - SW'(1);
    side_run = !(s_w < SW'(m));
    first_w  = side_run ? (s_w - SW'(m)) : s_w;
  end

  // scan addressing: kind 0 walks a row of the column store, kind 1 a column
  // of the row store
  assign issue   = (ctrl.op == OP_ISSUE_A) || (ctrl.op == OP_ISSUE_B);
  assign kind    = (ctrl.op == OP_ISSUE_A) ? side_q : !side_q;
  assign fixed   = (ctrl.op == OP_ISSUE_A) ? first_q : resp_q;
  assign len     = kind ? m : n;
  assign rd_addr = kind ? {t_q, fixed} : {fixed, t_q};

  assign in_range = (32'(item_q.cell_row) < MAX_STRATEGIES) &&
                    (32'(item_q.cell_col) < MAX_STRATEGIES);
  assign wr_addr  = {IDX_W'(item_q.cell_row), IDX_W'(item_q.cell_col)};

  assign stat.fire     = fire;
  assign stat.early    = (item_q.func == FUNC_LOAD) || bad;
  assign stat.more     = (CNT_W'(t_q) + CNT_W'(1)) < len;
  assign stat.out_free = !out_vld_q || out_ready_i;

  hanbr_scan #(
    .MAX_STRATEGIES (MAX_STRATEGIES),
    .PAYOFF_WIDTH   (PAYOFF_WIDTH)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    ((ctrl.op == OP_DECODE) && (item_q.func == FUNC_LOAD) && in_range),
    .wr_addr_i  (wr_addr),
    .wr_row_i   (to_payoff(item_q.row_payoff)),
    .wr_col_i   (to_payoff(item_q.col_payoff)),
    .rd_en_i    (issue),
    .rd_addr_i  (rd_addr),
    .rd_kind_i  (kind),
    .rd_idx_i   (t_q),
    .best_idx_o (best)
  );

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= COUNT_W'(1);
      col_cnt_q <= COUNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_ROW_COUNT) begin
        row_cnt_q <= cfg_data_i[COUNT_W-1:0];
      end else if (cfg_index_i == REG_COL_COUNT) begin
        col_cnt_q <= cfg_data_i[COUNT_W-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= in_item_i;
    end
    case (ctrl.op)
      OP_DECODE: begin
        res_q   <= '{status: ((item_q.func == FUNC_RUN) && bad) ? STATUS_BAD : STATUS_OK,
                     default: '0};
        side_q  <= side_run;
        first_q <= IDX_W'(first_w);
        t_q     <= '0;
      end
      OP_ISSUE_A, OP_ISSUE_B: begin
        t_q <= t_q + IDX_W'(1);
      end
      OP_TAKE_RESP: begin
        resp_q <= best;
        t_q    <= '0;
      end
      OP_FINISH: begin
        res_q <= '{status:            STATUS_OK,
                   player_side:       side_q,
                   first_strategy:    6'(first_q),
                   response_strategy: 6'(resp_q),
                   second_strategy:   6'(best),
                   support_size:      (first_q == best) ? SUPPORT_PAIR : SUPPORT_TRIPLE};
      end
      default: begin
      end
    endcase
    if ((ctrl.op == OP_EMIT) && stat.out_free) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((ctrl.op == OP_EMIT) && stat.out_free) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ===== design/hanbr_seq.sv =====
// ----------------------------------------------------------------------------
// hanbr_seq
// Step counter and program table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module hanbr_seq import hanbr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_stat_t stat_i,
  output ctrl_t     ctrl_o
);

  pc_t   pc_q, pc_d;
  ctrl_t cw;

  assign cw     = ucode(pc_q);
  assign ctrl_o = cw;

  always_comb begin
    pc_d = pc_q + 4'd1;
    case (cw.cond)
      C_NEXT:     pc_d = pc_q + 4'd1;
      C_ACCEPT:   pc_d = stat_i.fire ? pc_q + 4'd1 : pc_q;
      C_EARLY:    pc_d = stat_i.early ? cw.target : pc_q + 4'd1;
      C_MORE:     pc_d = stat_i.more ? cw.target : pc_q + 4'd1;
      C_OUT_FREE: pc_d = stat_i.out_free ? cw.target : pc_q;
      C_JUMP:     pc_d = cw.target;
      default:    pc_d = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== design/hanbr_scan.sv =====
// ----------------------------------------------------------------------------
// hanbr_scan
// Payoff memories and the argmax compare stage behind their read port.
// ----------------------------------------------------------------------------
module hanbr_scan import hanbr_pkg::*; #(
  parameter int MAX_STRATEGIES = 64,
  parameter int PAYOFF_WIDTH   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [2*$clog2(MAX_STRATEGIES)-1:0] wr_addr_i,
  input  logic [PAYOFF_WIDTH-1:0]           wr_row_i,
  input  logic [PAYOFF_WIDTH-1:0]           wr_col_i,
  input  logic                              rd_en_i,
  input  logic [2*$clog2(MAX_STRATEGIES)-1:0] rd_addr_i,
  input  logic                              rd_kind_i,
  input  logic [$clog2(MAX_STRATEGIES)-1:0] rd_idx_i,
  output logic [$clog2(MAX_STRATEGIES)-1:0] best_idx_o
);

  localparam int IDX_W = $clog2(MAX_STRATEGIES);
  localparam int AW    = 2 * IDX_W;
  localparam int DEPTH = 1 << AW;

  logic [PAYOFF_WIDTH-1:0] row_mem [DEPTH];
  logic [PAYOFF_WIDTH-1:0] col_mem [DEPTH];

  logic [PAYOFF_WIDTH-1:0] row_rd_q, col_rd_q;
  logic                    rd_vld_q;
  logic                    rd_kind_q;
  logic [IDX_W-1:0]        rd_idx_q;

  logic signed [PAYOFF_WIDTH-1:0] cand;
  logic signed [PAYOFF_WIDTH-1:0] best_val_q;
  logic [IDX_W-1:0]               best_idx_q;
  logic                           take;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      row_mem[wr_addr_i] <= wr_row_i;
      col_mem[wr_addr_i] <= wr_col_i;
    end
    if (rd_en_i) begin
      row_rd_q <= row_mem[rd_addr_i];
      col_rd_q <= col_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_kind_q <= rd_kind_i;
    rd_idx_q  <= rd_idx_i;
  end

  // kind 0 scans the column player's payoffs, kind 1 the row player's
  assign cand = rd_kind_q ? $signed(row_rd_q) : $signed(col_rd_q);
  // ties move the leader to the later index
  assign take = rd_vld_q && ((rd_idx_q == '0) || (cand >= best_val_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_val_q <= cand;
      best_idx_q <= rd_idx_q;
    end
  end

  assign best_idx_o = best_idx_q;

endmodule

// ===== tb/sv/half_approx_nash_best_response_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// half_approx_nash_best_response_unit_tb
// Loads payoff cells, runs best-response chains from many start strategies
// under several count settings and handshake idling patterns, and checks every
// result item against a fixed expected item or a shadow of the payoff tables and the argmax scans.
// ----------------------------------------------------------------------------
module half_approx_nash_best_response_unit_tb;
  import hanbr_pkg::*;

  localparam int N_STRAT      = 64;
  localparam int N_PHASES     = 10;
  localparam int PHASE_ITEMS  = 140;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 200;

  typedef enum logic [1:0] {ROW_LOAD, ROW_RUN, ROW_CFG} step_kind_e;

  // ROW_CFG rows carry row_count / col_count in the payoff columns
  typedef struct packed {
    step_kind_e  kind;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [31:0] row_payoff;
    logic [31:0] col_payoff;
    logic [7:0]  start;
    logic        typed;
    out_item_t   want;
  } step_t;

  localparam out_item_t RES_ZERO = '0;
  localparam out_item_t RES_BAD  = '{status: STATUS_BAD, default: '0};
  localparam out_item_t RES_ROW0 = '{STATUS_OK, 1'b0, 6'd0, 6'd0, 6'd0, SUPPORT_PAIR};
  localparam out_item_t RES_COL0 = '{STATUS_OK, 1'b1, 6'd0, 6'd0, 6'd0, SUPPORT_PAIR};

  localparam int N_DIRECTED = 21;
  step_t directed_steps [N_DIRECTED] = '{
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd0,   1'b1, RES_BAD},
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd3,   1'b1, RES_BAD},
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd255, 1'b1, RES_BAD},
    '{ROW_LOAD, 6'd0,  6'd0,  32'h7FFF_FFFF, 32'h8000_0000, 8'd0,   1'b1, RES_ZERO},
    '{ROW_LOAD, 6'd63, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0,   1'b1, RES_ZERO},
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd1,   1'b1, RES_ROW0},
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd2,   1'b1, RES_COL0},
    '{ROW_CFG,  6'd0,  6'd0,  32'd2,         32'd2,         8'd0,   1'b0, RES_ZERO},
    '{ROW_LOAD, 6'd0,  6'd1,  32'h7FFF_FFFF, 32'h8000_0000, 8'd0,   1'b1, RES_ZERO},
    '{ROW_LOAD, 6'd1,  6'd0,  32'h0,         32'h0,         8'd0,   1'b1, RES_ZERO},
    '{ROW_LOAD, 6'd1,  6'd1,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'd0,   1'b1, RES_ZERO},
    // ties on both scans go to the later index
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd1,   1'b0, RES_ZERO},
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd2,   1'b0, RES_ZERO},
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd3,   1'b0, RES_ZERO},
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd4,   1'b0, RES_ZERO},
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd5,   1'b1, RES_BAD},
    // zero count acts as one, oversize count as the maximum
    '{ROW_CFG,  6'd0,  6'd0,  32'd0,         32'd127,       8'd0,   1'b0, RES_ZERO},
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd66,  1'b1, RES_BAD},
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd0,   1'b1, RES_BAD},
    '{ROW_CFG,  6'd0,  6'd0,  32'd127,       32'd0,         8'd0,   1'b0, RES_ZERO},
    '{ROW_RUN,  6'd0,  6'd0,  32'h0,         32'h0,         8'd66,  1'b1, RES_BAD}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the block
  logic signed [31:0] row_pay [N_STRAT*N_STRAT];
  logic signed [31:0] col_pay [N_STRAT*N_STRAT];
  bit                 cell_loaded [N_STRAT*N_STRAT];
  int                 rows_eff = 1;
  int                 cols_eff = 1;

  out_item_t   pending_profiles [$];
  int          items_sent = 0;
  int          mismatches = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  always #5 clk = ~clk;

  half_approx_nash_best_response_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  function automatic int clamp_count(input logic [COUNT_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > N_STRAT) return N_STRAT;
    return int'(v);
  endfunction

  // argmax over the other player's payoffs; later index wins a tie
  function automatic logic [5:0] best_reply(input int s, input bit side);
    int b;
    b = 0;
    if (!side) begin
      for (int t = 1; t < cols_eff; t++)
        if (col_pay[s*N_STRAT + t] >= col_pay[s*N_STRAT + b]) b = t;
    end else begin
      for (int t = 1; t < rows_eff; t++)
        if (row_pay[t*N_STRAT + s] >= row_pay[b*N_STRAT + s]) b = t;
    end
    return 6'(b);
  endfunction

  function automatic out_item_t profile_of(input in_item_t it);
    out_item_t  res;
    int         s;
    int         first;
    bit         side;
    logic [5:0] resp;
    logic [5:0] second;
    res = '0;
    if (it.func == FUNC_LOAD) begin
      row_pay[{it.cell_row, it.cell_col}] = it.row_payoff;
      col_pay[{it.cell_row, it.cell_col}] = it.col_payoff;
      cell_loaded[{it.cell_row, it.cell_col}] = 1'b1;
      return res;
    end
    s = int'(it.start_strategy) - 1;
    if (s < 0 || s >= rows_eff + cols_eff) begin
      res.status = STATUS_BAD;
      return res;
    end
    side   = (s >= rows_eff);
    first  = side ? s - rows_eff : s;
    resp   = best_reply(first, side);
    second = best_reply(int'(resp), !side);
    res.status            = STATUS_OK;
    res.player_side       = side;
    res.first_strategy    = 6'(first);
    res.response_strategy = resp;
    res.second_strategy   = second;
    res.support_size      = (6'(first) == second) ? SUPPORT_PAIR : SUPPORT_TRIPLE;
    return res;
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.func           = 1'($urandom());
    it.cell_row       = 6'($urandom());
    it.cell_col       = 6'($urandom());
    it.row_payoff     = $urandom();
    it.col_payoff     = $urandom();
    it.start_strategy = 8'($urandom());
    return it;
  endfunction

  // small values give ties, the rest hits the extremes or any bit pattern
  function automatic logic [31:0] rand_payoff();
    case ($urandom_range(3))
      0:       return $urandom_range(2) - 1;
      1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input in_item_t it, input logic typed, input out_item_t typed_res);
    out_item_t want;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready_o);
    want = profile_of(it);
    pending_profiles.push_back(typed ? typed_res : want);
    items_sent++;
  endtask

  task automatic send_load(input int r, input int c);
    in_item_t it;
    it            = noise_item();
    it.func       = FUNC_LOAD;
    it.cell_row   = 6'(r);
    it.cell_col   = 6'(c);
    it.row_payoff = rand_payoff();
    it.col_payoff = rand_payoff();
    send_item(it, 1'b0, RES_ZERO);
  endtask

  // load whatever cells the scan best_reply(idx, side) will read
  task automatic cover_line(input bit side, input int idx);
    int r;
    int c;
    for (int t = 0; t < (side ? rows_eff : cols_eff); t++) begin
      r = side ? t : idx;
      c = side ? idx : t;
      if (!cell_loaded[r*N_STRAT + c]) send_load(r, c);
    end
  endtask

  task automatic issue_run(input logic [7:0] start);
    in_item_t it;
    int       s;
    int       first;
    bit       side;
    s = int'(start) - 1;
    if (s >= 0 && s < rows_eff + cols_eff) begin
      side  = (s >= rows_eff);
      first = side ? s - rows_eff : s;
      cover_line(side, first);
      cover_line(!side, int'(best_reply(first, side)));
    end
    it                = noise_item();
    it.func           = FUNC_RUN;
    it.start_strategy = start;
    send_item(it, 1'b0, RES_ZERO);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_profiles.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == REG_ROW_COUNT) rows_eff = clamp_count(data[COUNT_W-1:0]);
    else if (idx == REG_COL_COUNT) cols_eff = clamp_count(data[COUNT_W-1:0]);
    @(posedge clk);
  endtask

  task automatic write_counts(input logic [COUNT_W-1:0] r, input logic [COUNT_W-1:0] c);
    write_reg(REG_ROW_COUNT, {25'($urandom()), r});
    write_reg(REG_COL_COUNT, {25'($urandom()), c});
  endtask

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_profiles.size() == 0) begin
        mismatches++;
        $error("unexpected result item %p", out_item_o);
      end else begin
        want = pending_profiles.pop_front();
        if (out_item_o.status !== want.status) begin
          mismatches++;
          $error("status: expected %0d, got %0d", want.status, out_item_o.status);
        end
        if (out_item_o.player_side !== want.player_side) begin
          mismatches++;
          $error("player_side: expected %0d, got %0d", want.player_side,
                 out_item_o.player_side);
        end
        if (out_item_o.first_strategy !== want.first_strategy) begin
          mismatches++;
          $error("first_strategy: expected %0d, got %0d", want.first_strategy,
                 out_item_o.first_strategy);
        end
        if (out_item_o.response_strategy !== want.response_strategy) begin
          mismatches++;
          $error("response_strategy: expected %0d, got %0d", want.response_strategy,
                 out_item_o.response_strategy);
        end
        if (out_item_o.second_strategy !== want.second_strategy) begin
          mismatches++;
          $error("second_strategy: expected %0d, got %0d", want.second_strategy,
                 out_item_o.second_strategy);
        end
        if (out_item_o.support_size !== want.support_size) begin
          mismatches++;
          $error("support_size: expected %0d, got %0d", want.support_size,
                 out_item_o.support_size);
        end
      end
    end
  end

  initial begin
    step_t            step;
    in_item_t         it;
    int               goal;
    int               k;
    int unsigned      pick;
    logic [COUNT_W-1:0] r_raw;
    logic [COUNT_W-1:0] c_raw;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      step = directed_steps[i];
      if (step.kind == ROW_CFG) begin
        wait_drained();
        write_counts(step.row_payoff[COUNT_W-1:0], step.col_payoff[COUNT_W-1:0]);
      end else begin
        it                = '0;
        it.func           = (step.kind == ROW_RUN) ? FUNC_RUN : FUNC_LOAD;
        it.cell_row       = step.cell_row;
        it.cell_col       = step.cell_col;
        it.row_payoff     = step.row_payoff;
        it.col_payoff     = step.col_payoff;
        it.start_strategy = step.start;
        send_item(it, step.typed, step.want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin r_raw = 7'd0;   c_raw = 7'd0;   end
        1: begin r_raw = 7'd64;  c_raw = 7'd64;  end
        2: begin r_raw = 7'd127; c_raw = 7'd2;   end
        3: begin r_raw = 7'd3;   c_raw = 7'd100; end
        default: begin
          r_raw = 7'($urandom_range(8, 1));
          c_raw = 7'($urandom_range(8, 1));
        end
      endcase
      write_counts(r_raw, c_raw);
      // unmapped register index: must be ignored
      write_reg(8'($urandom_range(255, 2)), $urandom());

      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 48; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 48; end
        default: begin snd_idle_pct = 8; rcv_stall_pct = 8; end
      endcase
      // long receiver hold-off while the sender keeps pushing
      if (ph % 2 == 0) hold_requests <= hold_requests + 1;

      k    = 0;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        if (k == 60) wait_drained();
        pick = $urandom_range(99);
        if (pick < 45)
          issue_run(8'($urandom_range(rows_eff + cols_eff, 1)));
        else if (pick < 55)
          issue_run($urandom_range(1) ? 8'd0 :
                    8'($urandom_range(255, rows_eff + cols_eff + 1)));
        else if (pick < 80)
          send_load($urandom_range(rows_eff - 1), $urandom_range(cols_eff - 1));
        else
          send_load($urandom_range(N_STRAT - 1), $urandom_range(N_STRAT - 1));
        k++;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_profiles.size() != 0) begin
      mismatches++;
      $error("%0d result items never arrived", pending_profiles.size());
    end
    if (mismatches == 0) begin
      $display("** half_approx_nash_best_response_unit: PASSED **");
    end else begin
      $display("** half_approx_nash_best_response_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** half_approx_nash_best_response_unit: FAILED **");
    $finish;
  end

endmodule
